// ----- rtl/r2fft_pkg.sv -----
package r2fft_pkg;
  localparam int MaxPoints = 64;
  localparam int DefPoints = 64;
  localparam int SampleW = 16;
  localparam int BinW = 22;
  localparam int StoreW = 2 * BinW;
  localparam int TwW = 16;
  localparam logic signed [BinW-1:0] BinHi = 22'sh1FFFFF;
  localparam logic signed [BinW-1:0] BinLo = -22'sh200000;

  // cosine of the first quarter turn in 1/64 steps, q1.15
  function automatic logic signed [TwW-1:0] quarter_cos(input logic [4:0] j);
    logic signed [TwW-1:0] v;
    unique case (j)
      5'd0: v = 16'sd32767;
      5'd1: v = 16'sd32610;
      5'd2: v = 16'sd32138;
      5'd3: v = 16'sd31357;
      5'd4: v = 16'sd30274;
      5'd5: v = 16'sd28899;
      5'd6: v = 16'sd27246;
      5'd7: v = 16'sd25330;
      5'd8: v = 16'sd23170;
      5'd9: v = 16'sd20788;
      5'd10: v = 16'sd18205;
      5'd11: v = 16'sd15447;
      5'd12: v = 16'sd12540;
      5'd13: v = 16'sd9512;
      5'd14: v = 16'sd6393;
      5'd15: v = 16'sd3212;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [TwW-1:0] cos_at(input logic [4:0] j);
    logic [4:0] n;
    n = 5'd0 - j;
    if (j == 5'd16) return 16'sd0;
    return (j < 5'd16) ? quarter_cos(j) : -quarter_cos(n);
  endfunction

  function automatic logic signed [TwW-1:0] sin_at(input logic [4:0] j);
    logic [4:0] a;
    logic [4:0] b;
    a = 5'd16 - j;
    b = j - 5'd16;
    if (j == 5'd0) return 16'sd0;
    return (j <= 5'd16) ? quarter_cos(a) : quarter_cos(b);
  endfunction

  function automatic logic signed [BinW-1:0] sat22(input logic signed [BinW+1:0] v);
    if (v > BinHi) return BinHi;
    if (v < BinLo) return BinLo;
    return v[BinW-1:0];
  endfunction
endpackage

// ----- rtl/r2fft_ram.sv -----
module r2fft_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/r2fft_bfly.sv -----
// pipelined butterfly: t = b * w, top = a + t, bottom = a - t
module r2fft_bfly
  import r2fft_pkg::*;
(
  input  logic                   clk,
  input  logic signed [BinW-1:0] a_re,
  input  logic signed [BinW-1:0] a_im,
  input  logic signed [BinW-1:0] b_re,
  input  logic signed [BinW-1:0] b_im,
  input  logic signed [TwW-1:0]  c,
  input  logic signed [TwW-1:0]  s,
  output logic signed [BinW-1:0] top_re,
  output logic signed [BinW-1:0] top_im,
  output logic signed [BinW-1:0] bot_re,
  output logic signed [BinW-1:0] bot_im
);
  localparam int PW = BinW + TwW;
  logic signed [PW-1:0] p_rc, p_is, p_ic, p_rs;
  logic signed [BinW-1:0] a_re_d, a_im_d;
  logic signed [PW:0] t_re_full, t_im_full;
  logic signed [PW-15:0] t_re, t_im;

  always_ff @(posedge clk) begin
    p_rc <= b_re * c;
    p_is <= b_im * s;
    p_ic <= b_im * c;
    p_rs <= b_re * s;
    a_re_d <= a_re;
    a_im_d <= a_im;
  end

  always_comb begin
    t_re_full = PW'(p_rc) + PW'(p_is) + (PW+1)'(16384);
    t_im_full = PW'(p_ic) - PW'(p_rs) + (PW+1)'(16384);
    t_re = t_re_full[PW:15];
    t_im = t_im_full[PW:15];
  end

  always_ff @(posedge clk) begin
    top_re <= sat22((BinW+2)'(a_re_d) + (BinW+2)'(t_re));
    top_im <= sat22((BinW+2)'(a_im_d) + (BinW+2)'(t_im));
    bot_re <= sat22((BinW+2)'(a_re_d) - (BinW+2)'(t_re));
    bot_im <= sat22((BinW+2)'(a_im_d) - (BinW+2)'(t_im));
  end
endmodule

// ----- rtl/radix2_fft_frame.sv -----
// channel  dir  beat content (tdata low bit first)            end mark
// s_axis   in   sample_real[15:0], sample_imag[31:16]        none
// m_axis   out  bin_real[21:0], bin_imag[43:22], pad[47:44]  tlast = bin_last
//
// a frame is POINTS input beats, loaded at one beat per cycle while
// s_axis_tvalid is high, into the store in bit-reversed order. the
// butterfly sequencer does log2(POINTS) passes of POINTS/2 butterflies
// (read top, read bottom, wait and settle for the butterfly pipeline,
// write top, write bottom), then POINTS bins leave at up to one per cycle
// through a one-entry output register. the store's one read and one write
// port set the pace. a new frame waits until the last bin is in the output
// register. rst clears control only; a stall on m_axis holds the unload.
module radix2_fft_frame
  import r2fft_pkg::*;
#(
  parameter int POINTS = DefPoints
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample_real, sample_imag
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // bin_real, bin_imag, zero pad
  output logic        m_axis_tlast
);
  localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int SW = $clog2(AW + 1);
  localparam logic [2:0] StLoad = 3'd0, StRdA = 3'd1, StRdB = 3'd2,
    StWait = 3'd3, StWrA = 3'd4, StWrB = 3'd5, StOut = 3'd6, StSettle = 3'd7;

  logic [2:0] state;
  logic [AW-1:0] cnt;       // sample or bin index
  logic [AW-1:0] bf;        // butterfly index in pass
  logic [SW-1:0] pass;      // pass number, span = 2 << pass
  logic outv;
  logic rd_pend, rd_last;
  logic [AW-1:0] rev;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [StoreW-1:0] wdata, rdata;
  logic [AW-1:0] ia, ib;
  logic [AW-1:0] kidx, lowmask;
  logic [4:0] tw;
  logic signed [BinW-1:0] a_re, a_im;
  logic signed [BinW-1:0] top_re, top_im, bot_re, bot_im;

  r2fft_ram #(.Width(StoreW), .Depth(POINTS)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  r2fft_bfly u_bfly (
    .clk(clk), .a_re(a_re), .a_im(a_im),
    .b_re(rdata[BinW-1:0]), .b_im(rdata[StoreW-1:BinW]),
    .c(cos_at(tw)), .s(sin_at(tw)),
    .top_re(top_re), .top_im(top_im), .bot_re(bot_re), .bot_im(bot_im)
  );

  always_comb begin
    for (int i = 0; i < AW; i++) rev[i] = cnt[AW-1-i];
    lowmask = AW'((1 << pass) - 1);
    kidx = bf & lowmask;
    ia = AW'(((bf & ~lowmask) << 1) | kidx);
    ib = AW'(ia | (AW'(1) << pass));
    tw = 5'(32'(kidx) << (6 - 32'(pass) - 1));
  end

  // take of a waiting bin issues the next read; otherwise re-read to hold rdata
  logic take;
  assign take = rd_pend && (!outv || m_axis_tready);

  always_comb begin
    we = 1'b0;
    waddr = rev;
    wdata = {{(BinW-SampleW){s_axis_tdata[31]}}, s_axis_tdata[31:16],
             {(BinW-SampleW){s_axis_tdata[15]}}, s_axis_tdata[15:0]};
    raddr = ia;
    unique case (state)
      StLoad: we = s_axis_tvalid;
      // bottom stays on the read port until the pipeline has taken it twice
      StRdB, StWait: raddr = ib;
      StWrA: begin
        we = 1'b1; waddr = ia; wdata = {top_im, top_re};
      end
      StWrB: begin
        we = 1'b1; waddr = ib; wdata = {bot_im, bot_re};
      end
      StOut: raddr = (rd_pend && !take) ? cnt - 1'b1 : cnt;
      default: ;
    endcase
  end

  assign s_axis_tready = (state == StLoad);

  always_ff @(posedge clk) begin
    if (state == StRdB) begin
      a_re <= signed'(rdata[BinW-1:0]);
      a_im <= signed'(rdata[StoreW-1:BinW]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StLoad;
      cnt <= '0; bf <= '0; pass <= '0;
      outv <= 1'b0; rd_pend <= 1'b0; rd_last <= 1'b0;
    end else begin
      if (take) begin
        outv <= 1'b1;
        m_axis_tdata <= {4'b0, rdata};
        m_axis_tlast <= rd_last;
      end else if (m_axis_tready) begin
        outv <= 1'b0;
      end
      unique case (state)
        StLoad: if (s_axis_tvalid) begin
          cnt <= cnt + 1'b1;
          if (cnt == AW'(POINTS - 1)) state <= StRdA;
        end
        StRdA: state <= StRdB;
        StRdB: state <= StWait;
        StWait: state <= StSettle;
        StSettle: state <= StWrA;
        StWrA: state <= StWrB;
        StWrB: begin
          if (bf == AW'(POINTS / 2 - 1)) begin
            bf <= '0;
            if (pass == SW'(AW - 1)) begin
              pass <= '0; state <= StOut; cnt <= '0;
            end else begin
              pass <= pass + 1'b1; state <= StRdA;
            end
          end else begin
            bf <= bf + 1'b1; state <= StRdA;
          end
        end
        StOut: if (!rd_pend || take) begin
          if (!(rd_pend && rd_last)) begin
            rd_pend <= 1'b1;
            rd_last <= (cnt == AW'(POINTS - 1));
            cnt <= cnt + 1'b1;
          end else begin
            rd_pend <= 1'b0;
            state <= StLoad; cnt <= '0;
          end
        end
        default: state <= StLoad;
      endcase
    end
  end

  assign m_axis_tvalid = outv;
endmodule

// ----- rtl/r2fft_check.sv -----
module r2fft_check (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");
  a_ready_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> s_axis_tready && !m_axis_tvalid)
    else $error("not idle after reset");
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[47:44] == 4'b0)
    else $error("pad bits set");
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("beat after last bin");
endmodule

bind radix2_fft_frame r2fft_check u_check (.*);
